### hw/rtl/wsc_pkg.sv
`timescale 1ns / 1ps

package wsc_pkg;

  localparam int NUM_WHEELS = 4;
  localparam int WHEEL_W    = 2;

  localparam int VEL_W   = 32;
  localparam int RAD_W   = 16;
  localparam int MS_W    = 24;
  localparam int PULSE_W = 12;
  localparam int PROD_W  = VEL_W + RAD_W;
  localparam int QUO_W   = 16;

  localparam int BITS_PER_STAGE = 2;
  localparam int DIV_STAGES     = QUO_W / BITS_PER_STAGE;

  localparam logic [7:0]  CMD_SET_TARGET = 8'h84;
  localparam logic [16:0] ONE_Q16        = 17'h10000;
  localparam logic signed [32:0] HALF_Q16 = 33'sd32768;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_ADDR_W-1:0] REG_RADIUS        = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_MAX_SPEED     = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_PULSE_MIN     = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_PULSE_NEUTRAL = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_PULSE_MAX     = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_INVERT_MASK   = 3'd5;
  localparam logic [CFG_ADDR_W-1:0] REG_CHANNEL_MAP   = 3'd6;

  typedef struct packed {
    logic [RAD_W-1:0]   radius;
    logic [MS_W-1:0]    max_speed;
    logic [PULSE_W-1:0] pulse_min;
    logic [PULSE_W-1:0] pulse_neutral;
    logic [PULSE_W-1:0] pulse_max;
    logic [1:0]         invert_mask;
    logic [31:0]        channel_map;
  } cfg_t;

  // one item in flight through the divider
  typedef struct packed {
    logic               neutral;
    logic [WHEEL_W-1:0] wheel;
    logic               neg;
    logic               sat;
    logic               zero;
    logic [MS_W-1:0]    rem;
    logic [QUO_W-1:0]   num_lo;
    logic [QUO_W-1:0]   quo;
  } div_tok_t;

  typedef struct packed {
    logic [7:0] channel;
    logic [6:0] lo7;
    logic [6:0] hi7;
  } cmd_t;

  // restoring division, BITS_PER_STAGE quotient bits
  function automatic div_tok_t div_step(input div_tok_t t, input logic [MS_W-1:0] ms);
    div_tok_t o;
    logic [MS_W:0] r;
    o = t;
    for (int b = 0; b < BITS_PER_STAGE; b++) begin
      r = {o.rem, o.num_lo[QUO_W-1]};
      o.num_lo = {o.num_lo[QUO_W-2:0], 1'b0};
      if (r >= {1'b0, ms}) begin
        o.rem = MS_W'(r - {1'b0, ms});
        o.quo = {o.quo[QUO_W-2:0], 1'b1};
      end else begin
        o.rem = r[MS_W-1:0];
        o.quo = {o.quo[QUO_W-2:0], 1'b0};
      end
    end
    return o;
  endfunction

endpackage

### hw/rtl/wsc_front.sv
`timescale 1ns / 1ps

module wsc_front (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         en,
  input  wsc_pkg::cfg_t                cfg,
  input  logic                         in_valid,
  input  logic                         in_neutral,
  input  logic [wsc_pkg::WHEEL_W-1:0]  in_wheel,
  input  logic [wsc_pkg::VEL_W-1:0]    in_vel,
  output logic                         tok_valid,
  output wsc_pkg::div_tok_t            tok
);

  localparam int PW = wsc_pkg::PROD_W;

  logic                        v1_r, v2_r, v3_r;
  logic                        neutral1_r, neutral2_r;
  logic [wsc_pkg::WHEEL_W-1:0] wheel1_r, wheel2_r;
  logic                        inv1_r;
  logic signed [PW-1:0]        prod1_r;
  logic [PW-1:0]               mag2_r;
  logic                        neg2_r;
  wsc_pkg::div_tok_t           tok3_r;

  logic signed [PW-1:0] prod_nxt;
  logic                 item_ok;
  logic [PW-1:0]        ms_scaled;

  assign item_ok  = 32'(in_wheel) < wsc_pkg::NUM_WHEELS;
  assign prod_nxt = $signed({{(PW - wsc_pkg::VEL_W){in_vel[wsc_pkg::VEL_W-1]}}, in_vel}) *
                    $signed({{(PW - wsc_pkg::RAD_W){1'b0}}, cfg.radius});
  assign ms_scaled = {{(PW - wsc_pkg::MS_W - wsc_pkg::QUO_W){1'b0}}, cfg.max_speed,
                      {wsc_pkg::QUO_W{1'b0}}};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid && item_ok;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // stage 1: linear speed
      neutral1_r <= in_neutral;
      wheel1_r   <= in_wheel;
      inv1_r     <= cfg.invert_mask[in_wheel[0]];
      prod1_r    <= prod_nxt;
      // stage 2: magnitude and direction
      neutral2_r <= neutral1_r;
      wheel2_r   <= wheel1_r;
      neg2_r     <= prod1_r[PW-1] ^ inv1_r;
      mag2_r     <= prod1_r[PW-1] ? (~prod1_r + PW'(1)) : prod1_r;
      // stage 3: saturation check, divider setup
      tok3_r.neutral <= neutral2_r;
      tok3_r.wheel   <= wheel2_r;
      tok3_r.neg     <= neg2_r;
      tok3_r.sat     <= mag2_r >= ms_scaled;
      tok3_r.zero    <= mag2_r == '0;
      tok3_r.rem     <= mag2_r[wsc_pkg::QUO_W +: wsc_pkg::MS_W];
      tok3_r.num_lo  <= mag2_r[wsc_pkg::QUO_W-1:0];
      tok3_r.quo     <= '0;
    end
  end

  assign tok_valid = v3_r;
  assign tok       = tok3_r;

endmodule

### hw/rtl/wsc_div.sv
`timescale 1ns / 1ps

module wsc_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         en,
  input  logic [wsc_pkg::MS_W-1:0]     max_speed,
  input  logic                         tok_in_valid,
  input  wsc_pkg::div_tok_t            tok_in,
  output logic                         tok_out_valid,
  output wsc_pkg::div_tok_t            tok_out
);

  localparam int N = wsc_pkg::DIV_STAGES;

  logic              v_r   [N];
  wsc_pkg::div_tok_t tok_r [N];
  logic              src_v [N];
  wsc_pkg::div_tok_t src   [N];

  for (genvar s = 0; s < N; s++) begin : g_stage
    if (s == 0) begin : g_first
      assign src_v[s] = tok_in_valid;
      assign src[s]   = tok_in;
    end else begin : g_rest
      assign src_v[s] = v_r[s-1];
      assign src[s]   = tok_r[s-1];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[s] <= 1'b0;
      end else if (en) begin
        v_r[s] <= src_v[s];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        tok_r[s] <= wsc_pkg::div_step(src[s], max_speed);
      end
    end
  end

  assign tok_out_valid = v_r[N-1];
  assign tok_out       = tok_r[N-1];

endmodule

### hw/rtl/wsc_map.sv
`timescale 1ns / 1ps

module wsc_map (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  wsc_pkg::cfg_t      cfg,
  input  logic               tok_valid,
  input  wsc_pkg::div_tok_t  tok,
  output logic               cmd_valid,
  output wsc_pkg::cmd_t      cmd
);

  logic                        v1_r, v2_r;
  logic                        neutral1_r;
  logic [wsc_pkg::WHEEL_W-1:0] wheel1_r;
  logic signed [30:0]          prod1_r;
  wsc_pkg::cmd_t               cmd2_r;

  logic [16:0]        q;
  logic signed [12:0] span;
  logic signed [30:0] prod_nxt;
  logic signed [32:0] sum;
  logic [11:0]        pulse;
  logic [13:0]        target;

  always_comb begin
    if (tok.zero) begin
      q = '0;
    end else if (tok.sat) begin
      q = wsc_pkg::ONE_Q16;
    end else begin
      q = {1'b0, tok.quo};
    end
  end

  // reverse side folds the sign of the ratio into the span
  assign span = tok.neg ? ($signed({1'b0, cfg.pulse_min}) - $signed({1'b0, cfg.pulse_neutral}))
                        : ($signed({1'b0, cfg.pulse_max}) - $signed({1'b0, cfg.pulse_neutral}));
  assign prod_nxt = $signed({14'b0, q}) * $signed({{18{span[12]}}, span});

  assign sum = $signed({5'b0, cfg.pulse_neutral, 16'b0}) +
               $signed({{2{prod1_r[30]}}, prod1_r}) + wsc_pkg::HALF_Q16;
  assign pulse  = neutral1_r ? cfg.pulse_neutral : sum[27:16];
  assign target = {pulse, 2'b00};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (en) begin
      v1_r <= tok_valid;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      neutral1_r     <= tok.neutral;
      wheel1_r       <= tok.wheel;
      prod1_r        <= prod_nxt;
      cmd2_r.channel <= cfg.channel_map[{wheel1_r, 3'b000} +: 8];
      cmd2_r.lo7     <= target[6:0];
      cmd2_r.hi7     <= target[13:7];
    end
  end

  assign cmd_valid = v2_r;
  assign cmd       = cmd2_r;

endmodule

### hw/rtl/wsc_ser.sv
`timescale 1ns / 1ps

module wsc_ser (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           cmd_valid,
  input  wsc_pkg::cmd_t  cmd,
  output logic           ser_ready,
  output logic           out_tvalid,
  input  logic           out_tready,
  output logic [7:0]     out_tdata,
  output logic           out_tlast
);

  typedef enum logic [1:0] {
    BYTE_OP = 2'd0,
    BYTE_CH = 2'd1,
    BYTE_LO = 2'd2,
    BYTE_HI = 2'd3
  } byte_sel_t;

  logic          busy_r, busy_nxt;
  logic          pend_valid_r, pend_valid_nxt;
  byte_sel_t     idx_r, idx_nxt;
  wsc_pkg::cmd_t cur_r, cur_nxt;
  wsc_pkg::cmd_t pend_r, pend_nxt;

  logic take, done, free_cur, load;

  assign take      = out_tvalid && out_tready;
  assign done      = take && (idx_r == BYTE_HI);
  assign free_cur  = !busy_r || done;
  assign ser_ready = !pend_valid_r;
  assign load      = cmd_valid && ser_ready;

  always_comb begin
    busy_nxt       = busy_r;
    pend_valid_nxt = pend_valid_r;
    idx_nxt        = take ? byte_sel_t'(idx_r + 2'd1) : idx_r;
    cur_nxt        = cur_r;
    pend_nxt       = pend_r;
    if (free_cur) begin
      if (pend_valid_r) begin
        busy_nxt       = 1'b1;
        cur_nxt        = pend_r;
        pend_valid_nxt = 1'b0;
      end else if (load) begin
        busy_nxt = 1'b1;
        cur_nxt  = cmd;
      end else begin
        busy_nxt = 1'b0;
      end
    end else if (load) begin
      pend_valid_nxt = 1'b1;
      pend_nxt       = cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r       <= 1'b0;
      pend_valid_r <= 1'b0;
      idx_r        <= BYTE_OP;
    end else begin
      busy_r       <= busy_nxt;
      pend_valid_r <= pend_valid_nxt;
      idx_r        <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r  <= cur_nxt;
    pend_r <= pend_nxt;
  end

  always_comb begin
    unique case (idx_r)
      BYTE_OP: out_tdata = wsc_pkg::CMD_SET_TARGET;
      BYTE_CH: out_tdata = cur_r.channel;
      BYTE_LO: out_tdata = {1'b0, cur_r.lo7};
      BYTE_HI: out_tdata = {1'b0, cur_r.hi7};
      default: out_tdata = wsc_pkg::CMD_SET_TARGET;
    endcase
  end

  assign out_tvalid = busy_r;
  assign out_tlast  = idx_r == BYTE_HI;

  a_pend_needs_busy: assert property (@(posedge clk) disable iff (!rst_n)
    pend_valid_r |-> busy_r)
    else $error("waiting command without one in progress");

  a_handover: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && idx_r == BYTE_HI && pend_valid_r) |=>
    (busy_r && idx_r == BYTE_OP && !pend_valid_r))
    else $error("waiting command not started after last byte");

  a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd_valid && !pend_valid_r && busy_r &&
     !(out_tvalid && out_tready && idx_r == BYTE_HI)) |=> pend_valid_r)
    else $error("command lost while serializer busy");

endmodule

### hw/rtl/wheel_speed_to_servo_command.sv
`timescale 1ns / 1ps
// Turns wheel velocity requests into four-byte servo set-target commands.
// Input request: in_tdata carries the velocity (signed Q16.16 rad/s), in_tuser
// carries the request kind (speed or neutral) and the wheel number. Each
// request yields four bytes on the out_ stream: 0x84, channel, target bits
// 6..0, target bits 13..7, with out_tlast on the fourth byte.
// Registers are written through cfg_we/cfg_addr/cfg_wdata; the user must write
// them only while idle, which the block itself does not enforce. Pipeline: 13
// stages (multiply, magnitude, saturation check, eight two-bit divider stages,
// span multiply, rounding), then the byte serializer, which registers a command
// before it presents the first byte. Commands leave four bytes each through the
// single byte lane of the serializer, which holds one command in flight and one
// waiting.
// Reset (rst_n low, synchronous) empties the pipeline and the serializer and
// loads the register defaults. When the receiver stalls, the serializer fills
// its waiting slot, the pipeline then stops as a whole and in_tready drops;
// nothing is lost or repeated.

module wheel_speed_to_servo_command (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [31:0]                      in_tdata,   // [31:0] velocity
  input  logic [2:0]                       in_tuser,   // [0] req_type, [2:1] wheel
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [7:0]                       out_tdata,  // [7:0] cmd_byte
  output logic                             out_tlast,
  input  logic                             cfg_we,
  input  logic [wsc_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  logic [wsc_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  wsc_pkg::cfg_t     cfg_r;
  logic              en;
  logic              front_valid, div_valid, map_valid, ser_ready;
  wsc_pkg::div_tok_t front_tok, div_tok;
  wsc_pkg::cmd_t     map_cmd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.radius        <= 16'd6554;
      cfg_r.max_speed     <= 24'd65536;
      cfg_r.pulse_min     <= 12'd1000;
      cfg_r.pulse_neutral <= 12'd1500;
      cfg_r.pulse_max     <= 12'd2000;
      cfg_r.invert_mask   <= 2'd0;
      cfg_r.channel_map   <= 32'h03020100;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        wsc_pkg::REG_RADIUS:        cfg_r.radius        <= cfg_wdata[15:0];
        wsc_pkg::REG_MAX_SPEED:     cfg_r.max_speed     <= cfg_wdata[23:0];
        wsc_pkg::REG_PULSE_MIN:     cfg_r.pulse_min     <= cfg_wdata[11:0];
        wsc_pkg::REG_PULSE_NEUTRAL: cfg_r.pulse_neutral <= cfg_wdata[11:0];
        wsc_pkg::REG_PULSE_MAX:     cfg_r.pulse_max     <= cfg_wdata[11:0];
        wsc_pkg::REG_INVERT_MASK:   cfg_r.invert_mask   <= cfg_wdata[1:0];
        wsc_pkg::REG_CHANNEL_MAP:   cfg_r.channel_map   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // whole pipeline moves together unless its last stage is blocked
  assign en        = !map_valid || ser_ready;
  assign in_tready = en;

  wsc_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (en),
    .cfg        (cfg_r),
    .in_valid   (in_tvalid),
    .in_neutral (in_tuser[0]),
    .in_wheel   (in_tuser[2:1]),
    .in_vel     (in_tdata),
    .tok_valid  (front_valid),
    .tok        (front_tok)
  );

  wsc_div u_div (
    .clk           (clk),
    .rst_n         (rst_n),
    .en            (en),
    .max_speed     (cfg_r.max_speed),
    .tok_in_valid  (front_valid),
    .tok_in        (front_tok),
    .tok_out_valid (div_valid),
    .tok_out       (div_tok)
  );

  wsc_map u_map (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .cfg       (cfg_r),
    .tok_valid (div_valid),
    .tok       (div_tok),
    .cmd_valid (map_valid),
    .cmd       (map_cmd)
  );

  wsc_ser u_ser (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd_valid  (map_valid),
    .cmd        (map_cmd),
    .ser_ready  (ser_ready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule
